// ===== rtl/core/mcb_pkg.sv =====
package mcb_pkg;

  localparam int PixW   = 8;
  localparam int CoordW = 12;
  localparam int CountW = 25;
  localparam int DimW   = 13;
  localparam int CfgIdxW = 2;

  localparam logic [PixW-1:0]   PIX_MAX   = 8'd255;
  localparam logic [CountW-1:0] COUNT_MAX = 25'h1FF_FFFF;

  typedef enum logic [2:0] {
    MODE_REPLACE   = 3'd0,
    MODE_ADD       = 3'd1,
    MODE_SUBTRACT  = 3'd2,
    MODE_INTERSECT = 3'd3,
    MODE_INVERT    = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

endpackage

// ===== rtl/core/mcb_combine.sv =====
module mcb_combine (
  input  logic [2:0]                 mode_i,
  input  logic [mcb_pkg::PixW-1:0]   cur_i,
  input  logic [mcb_pkg::PixW-1:0]   nw_i,
  output logic [mcb_pkg::PixW-1:0]   res_o
);

  logic [2*mcb_pkg::PixW-1:0] prod;
  logic [2*mcb_pkg::PixW:0]   prod_adj;
  logic [mcb_pkg::PixW-1:0]   scaled;

  // floor(p / 255) for a 16-bit p
  assign prod     = cur_i * (mcb_pkg::PIX_MAX - nw_i);
  assign prod_adj = {1'b0, prod} + {{(mcb_pkg::PixW + 1){1'b0}}, prod[15:8]} + 17'd1;
  assign scaled   = prod_adj[15:8];

  always_comb begin
    case (mode_i)
      mcb_pkg::MODE_REPLACE:   res_o = nw_i;
      mcb_pkg::MODE_ADD:       res_o = (cur_i > nw_i) ? cur_i : nw_i;
      mcb_pkg::MODE_SUBTRACT:  res_o = scaled;
      mcb_pkg::MODE_INTERSECT: res_o = (cur_i < nw_i) ? cur_i : nw_i;
      mcb_pkg::MODE_INVERT:    res_o = (cur_i == '0) ? mcb_pkg::PIX_MAX : '0;
      default:                 res_o = cur_i;
    endcase
  end

endmodule

// ===== rtl/core/mask_combine_bbox_top.sv =====
// mask combiner with running bounding box
//
// input channel: one beat per pixel pair (current_pixel_i, new_pixel_i) in
// raster order, valid/ready handshake. output channel: one beat per input
// beat carrying the combined pixel, frame_last_o and the running box and
// count, which include the pixel of that beat and are final when
// frame_last_o is high.
// output valid rises in the cycle after input acceptance; throughput is one
// pixel per cycle unless the receiver stalls, limited only by the single
// output register. while the receiver stalls, the output register holds its
// beat and in_ready_o drops; it rises again in the cycle the beat is taken.
// configuration: cfg_we_i writes register cfg_idx_i (0 mode, 1 width,
// 2 height) at once; write only while no beat is in flight.
// reset clears the raster position, the frame statistics and the output
// valid flag, and sets mode to replace and width and height to 1.
// a dimension of 0 acts as 1, one above MAX_DIM acts as MAX_DIM.
module mask_combine_bbox_top #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mcb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mcb_pkg::DimW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mcb_pkg::PixW-1:0]      current_pixel_i,
  input  logic [mcb_pkg::PixW-1:0]      new_pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mcb_pkg::PixW-1:0]      result_pixel_o,
  output logic                          frame_last_o,
  output logic                          box_valid_o,
  output logic [mcb_pkg::CoordW-1:0]    box_min_x_o,
  output logic [mcb_pkg::CoordW-1:0]    box_min_y_o,
  output logic [mcb_pkg::CoordW-1:0]    box_max_x_o,
  output logic [mcb_pkg::CoordW-1:0]    box_max_y_o,
  output logic [mcb_pkg::CountW-1:0]    selected_count_o
);

  localparam int CW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int EW = ((CW > mcb_pkg::DimW) ? CW : mcb_pkg::DimW) + 1;
  localparam logic [EW-1:0] DIM_MAX  = EW'(MAX_DIM);
  localparam logic [EW-1:0] LAST_MAX = EW'(MAX_DIM - 1);

  logic [2:0]               mode_q;
  logic [mcb_pkg::DimW-1:0] width_q, height_q;

  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [CW-1:0] min_x_q, min_x_d, min_y_q, min_y_d;
  logic [CW-1:0] max_x_q, max_x_d, max_y_q, max_y_d;
  logic          any_q, any_d;
  logic [mcb_pkg::CountW-1:0] cnt_q, cnt_d;

  logic [CW-1:0] min_x_u, min_y_u, max_x_u, max_y_u;
  logic          any_u;
  logic [mcb_pkg::CountW-1:0] cnt_u;

  logic [EW-1:0] w_ext, h_ext, last_col, last_row;
  logic          row_end, last, nz, accept;
  logic [mcb_pkg::PixW-1:0] res;

  logic                       out_valid_q;
  logic [mcb_pkg::PixW-1:0]   res_q;
  logic                       last_q, any_out_q;
  logic [CW-1:0]              omin_x_q, omin_y_q, omax_x_q, omax_y_q;
  logic [mcb_pkg::CountW-1:0] ocnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mcb_pkg::MODE_REPLACE;
      width_q  <= mcb_pkg::DimW'(1);
      height_q <= mcb_pkg::DimW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mcb_pkg::CFG_MODE:   mode_q   <= cfg_data_i[2:0];
        mcb_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        mcb_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mcb_combine u_combine (
    .mode_i (mode_q),
    .cur_i  (current_pixel_i),
    .nw_i   (new_pixel_i),
    .res_o  (res)
  );

  // clamped last column and row index
  assign w_ext = EW'(width_q);
  assign h_ext = EW'(height_q);

  always_comb begin
    if (w_ext == '0) begin
      last_col = '0;
    end else if (w_ext > DIM_MAX) begin
      last_col = LAST_MAX;
    end else begin
      last_col = w_ext - EW'(1);
    end
    if (h_ext == '0) begin
      last_row = '0;
    end else if (h_ext > DIM_MAX) begin
      last_row = LAST_MAX;
    end else begin
      last_row = h_ext - EW'(1);
    end
  end

  assign row_end = (EW'(col_q) >= last_col);
  assign last    = row_end && (EW'(row_q) >= last_row);
  assign nz      = (res != '0);
  assign accept  = in_valid_i && in_ready_o;

  always_comb begin
    min_x_u = min_x_q;
    min_y_u = min_y_q;
    max_x_u = max_x_q;
    max_y_u = max_y_q;
    any_u   = any_q;
    cnt_u   = cnt_q;
    if (nz) begin
      any_u = 1'b1;
      if (!any_q) begin
        min_x_u = col_q;
        max_x_u = col_q;
        min_y_u = row_q;
        max_y_u = row_q;
      end else begin
        if (col_q < min_x_q) min_x_u = col_q;
        if (col_q > max_x_q) max_x_u = col_q;
        if (row_q < min_y_q) min_y_u = row_q;
        if (row_q > max_y_q) max_y_u = row_q;
      end
      if (cnt_q != mcb_pkg::COUNT_MAX) cnt_u = cnt_q + mcb_pkg::CountW'(1);
    end
  end

  always_comb begin
    if (last) begin
      col_d   = '0;
      row_d   = '0;
      min_x_d = '0;
      min_y_d = '0;
      max_x_d = '0;
      max_y_d = '0;
      any_d   = 1'b0;
      cnt_d   = '0;
    end else begin
      if (row_end) begin
        col_d = '0;
        row_d = row_q + CW'(1);
      end else begin
        col_d = col_q + CW'(1);
        row_d = row_q;
      end
      min_x_d = min_x_u;
      min_y_d = min_y_u;
      max_x_d = max_x_u;
      max_y_d = max_y_u;
      any_d   = any_u;
      cnt_d   = cnt_u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      min_x_q <= '0;
      min_y_q <= '0;
      max_x_q <= '0;
      max_y_q <= '0;
      any_q   <= 1'b0;
      cnt_q   <= '0;
    end else if (accept) begin
      col_q   <= col_d;
      row_q   <= row_d;
      min_x_q <= min_x_d;
      min_y_q <= min_y_d;
      max_x_q <= max_x_d;
      max_y_q <= max_y_d;
      any_q   <= any_d;
      cnt_q   <= cnt_d;
    end
  end

  // output register
  assign in_ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q     <= res;
      last_q    <= last;
      any_out_q <= any_u;
      omin_x_q  <= min_x_u;
      omin_y_q  <= min_y_u;
      omax_x_q  <= max_x_u;
      omax_y_q  <= max_y_u;
      ocnt_q    <= cnt_u;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_pixel_o   = res_q;
  assign frame_last_o     = last_q;
  assign box_valid_o      = any_out_q;
  assign box_min_x_o      = mcb_pkg::CoordW'(omin_x_q);
  assign box_min_y_o      = mcb_pkg::CoordW'(omin_y_q);
  assign box_max_x_o      = mcb_pkg::CoordW'(omax_x_q);
  assign box_max_y_o      = mcb_pkg::CoordW'(omax_y_q);
  assign selected_count_o = ocnt_q;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_DIM = 4096;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MISMATCH_SHOWN = 10;
  localparam int RANDOM_PIXELS = 900;
  localparam logic [2:0] MODE_SPARE_5 = 3'd5;
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  localparam logic [mcb_pkg::DimW-1:0] DIM_ZERO = '0;
  localparam logic [mcb_pkg::DimW-1:0] DIM_TOP = '1;

  typedef struct packed {
    logic [mcb_pkg::PixW-1:0]   pixel;
    logic                       last;
    logic                       box_valid;
    logic [mcb_pkg::CoordW-1:0] min_x;
    logic [mcb_pkg::CoordW-1:0] min_y;
    logic [mcb_pkg::CoordW-1:0] max_x;
    logic [mcb_pkg::CoordW-1:0] max_y;
    logic [mcb_pkg::CountW-1:0] count;
  } mask_beat_t;

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  mcb_pkg::cfg_idx_e          cfg_idx_i = mcb_pkg::CFG_MODE;
  logic [mcb_pkg::DimW-1:0]   cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [mcb_pkg::PixW-1:0]   current_pixel_i = '0;
  logic [mcb_pkg::PixW-1:0]   new_pixel_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [mcb_pkg::PixW-1:0]   result_pixel_o;
  logic                       frame_last_o;
  logic                       box_valid_o;
  logic [mcb_pkg::CoordW-1:0] box_min_x_o;
  logic [mcb_pkg::CoordW-1:0] box_min_y_o;
  logic [mcb_pkg::CoordW-1:0] box_max_x_o;
  logic [mcb_pkg::CoordW-1:0] box_max_y_o;
  logic [mcb_pkg::CountW-1:0] selected_count_o;

  mask_combine_bbox_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .current_pixel_i  (current_pixel_i),
    .new_pixel_i      (new_pixel_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_pixel_o   (result_pixel_o),
    .frame_last_o     (frame_last_o),
    .box_valid_o      (box_valid_o),
    .box_min_x_o      (box_min_x_o),
    .box_min_y_o      (box_min_y_o),
    .box_max_x_o      (box_max_x_o),
    .box_max_y_o      (box_max_y_o),
    .selected_count_o (selected_count_o)
  );

  // predicted block state
  logic [2:0]                 mode_reg = mcb_pkg::MODE_REPLACE;
  int                         width_reg = 1;
  int                         height_reg = 1;
  int                         col_pos = 0;
  int                         row_pos = 0;
  int                         box_x_lo = 0;
  int                         box_y_lo = 0;
  int                         box_x_hi = 0;
  int                         box_y_hi = 0;
  logic                       box_seen = 1'b0;
  logic [mcb_pkg::CountW-1:0] hit_count = '0;

  mask_beat_t pending_beats[$];
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  int         in_gap_max = 9;
  int         out_stall_max = 9;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic mask_beat_t combine_and_track(input logic [mcb_pkg::PixW-1:0] cur,
                                                   input logic [mcb_pkg::PixW-1:0] nw);
    mask_beat_t beat;
    logic [mcb_pkg::PixW-1:0] pix;
    int w;
    int h;
    logic row_end;
    logic last_px;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
    case (mode_reg)
      mcb_pkg::MODE_REPLACE:   pix = nw;
      mcb_pkg::MODE_ADD:       pix = (cur > nw) ? cur : nw;
      mcb_pkg::MODE_SUBTRACT:
        pix = mcb_pkg::PixW'((int'(cur) * (int'(mcb_pkg::PIX_MAX) - int'(nw)))
                             / int'(mcb_pkg::PIX_MAX));
      mcb_pkg::MODE_INTERSECT: pix = (cur < nw) ? cur : nw;
      mcb_pkg::MODE_INVERT:    pix = (cur == '0) ? mcb_pkg::PIX_MAX : '0;
      default:                 pix = cur;
    endcase
    row_end = (col_pos + 1 >= w);
    last_px = row_end && (row_pos + 1 >= h);
    if (pix != '0) begin
      if (!box_seen) begin
        box_x_lo = col_pos;
        box_x_hi = col_pos;
        box_y_lo = row_pos;
        box_y_hi = row_pos;
        box_seen = 1'b1;
      end else begin
        if (col_pos < box_x_lo) box_x_lo = col_pos;
        if (col_pos > box_x_hi) box_x_hi = col_pos;
        if (row_pos < box_y_lo) box_y_lo = row_pos;
        if (row_pos > box_y_hi) box_y_hi = row_pos;
      end
      if (hit_count != mcb_pkg::COUNT_MAX) hit_count = hit_count + mcb_pkg::CountW'(1);
    end
    beat.pixel     = pix;
    beat.last      = last_px;
    beat.box_valid = box_seen;
    beat.min_x     = box_seen ? mcb_pkg::CoordW'(box_x_lo) : '0;
    beat.min_y     = box_seen ? mcb_pkg::CoordW'(box_y_lo) : '0;
    beat.max_x     = box_seen ? mcb_pkg::CoordW'(box_x_hi) : '0;
    beat.max_y     = box_seen ? mcb_pkg::CoordW'(box_y_hi) : '0;
    beat.count     = hit_count;
    if (last_px) begin
      col_pos   = 0;
      row_pos   = 0;
      box_x_lo  = 0;
      box_y_lo  = 0;
      box_x_hi  = 0;
      box_y_hi  = 0;
      box_seen  = 1'b0;
      hit_count = '0;
    end else if (row_end) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return beat;
  endfunction

  function automatic void check_field(input string what,
                                      input logic [mcb_pkg::CountW-1:0] want,
                                      input logic [mcb_pkg::CountW-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MISMATCH_SHOWN)
        $display("mismatch in %s: expected %0d, got %0d", what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : monitor_proc
    mask_beat_t want;
    mask_beat_t fresh;
    logic in_beat;
    logic out_beat;
    in_beat  = in_valid_i && in_ready_o;
    out_beat = out_valid_o && out_ready_i;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mcb_pkg::CFG_MODE:   mode_reg = cfg_data_i[2:0];
          mcb_pkg::CFG_WIDTH:  width_reg = int'(cfg_data_i);
          mcb_pkg::CFG_HEIGHT: height_reg = int'(cfg_data_i);
          default:             ;
        endcase
      end
      if (out_beat) begin
        if (pending_beats.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MISMATCH_SHOWN)
            $display("result beat with nothing expected, pixel %0d", result_pixel_o);
        end else begin
          want = pending_beats.pop_front();
          check_field("result_pixel", mcb_pkg::CountW'(want.pixel),
                      mcb_pkg::CountW'(result_pixel_o));
          check_field("frame_last", mcb_pkg::CountW'(want.last),
                      mcb_pkg::CountW'(frame_last_o));
          check_field("box_valid", mcb_pkg::CountW'(want.box_valid),
                      mcb_pkg::CountW'(box_valid_o));
          check_field("box_min_x", mcb_pkg::CountW'(want.min_x),
                      mcb_pkg::CountW'(box_min_x_o));
          check_field("box_min_y", mcb_pkg::CountW'(want.min_y),
                      mcb_pkg::CountW'(box_min_y_o));
          check_field("box_max_x", mcb_pkg::CountW'(want.max_x),
                      mcb_pkg::CountW'(box_max_x_o));
          check_field("box_max_y", mcb_pkg::CountW'(want.max_y),
                      mcb_pkg::CountW'(box_max_y_o));
          check_field("selected_count", want.count, selected_count_o);
        end
      end
      if (in_beat) begin
        fresh = combine_and_track(current_pixel_i, new_pixel_i);
        pending_beats = {pending_beats, fresh};
      end
      if (in_beat || out_beat || cfg_we_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin : out_ready_proc
    int stall;
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // leaves valid high; the caller either sends again or waits for results
  task automatic send_pixel(input logic [mcb_pkg::PixW-1:0] cur,
                            input logic [mcb_pkg::PixW-1:0] nw);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    current_pixel_i <= cur;
    new_pixel_i     <= nw;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_all_results;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_beats.size() != 0);
  endtask

  task automatic load_settings(input logic [2:0] mode,
                               input logic [mcb_pkg::DimW-1:0] width,
                               input logic [mcb_pkg::DimW-1:0] height);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= mcb_pkg::CFG_MODE;
    cfg_data_i <= mcb_pkg::DimW'(mode);
    @(posedge clk_i);
    cfg_idx_i  <= mcb_pkg::CFG_WIDTH;
    cfg_data_i <= width;
    @(posedge clk_i);
    cfg_idx_i  <= mcb_pkg::CFG_HEIGHT;
    cfg_data_i <= height;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [mcb_pkg::PixW-1:0] pick_pixel();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return mcb_pkg::PIX_MAX;
      2:       return mcb_pkg::PixW'($urandom_range(1, 15));
      default: return mcb_pkg::PixW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [mcb_pkg::DimW-1:0] pick_dim();
    case ($urandom_range(0, 15))
      0:       return DIM_ZERO;
      1:       return mcb_pkg::DimW'(MAX_DIM);
      2:       return DIM_TOP;
      3:       return mcb_pkg::DimW'($urandom_range(MAX_DIM + 1, 8190));
      default: return mcb_pkg::DimW'($urandom_range(1, 8));
    endcase
  endfunction

  // mode replace and a 1x1 frame out of reset
  task automatic test_reset_defaults;
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd9, 8'd200);
    wait_all_results();
  endtask

  task automatic test_combine_modes;
    load_settings(mcb_pkg::MODE_REPLACE, 13'd4, 13'd2);
    send_pixel(8'd7, 8'd0);
    send_pixel(8'd0, 8'd255);
    wait_all_results();
    load_settings(mcb_pkg::MODE_ADD, 13'd4, 13'd2);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd3, 8'd200);
    wait_all_results();
    load_settings(mcb_pkg::MODE_SUBTRACT, 13'd4, 13'd2);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd200, 8'd100);
    wait_all_results();
    load_settings(mcb_pkg::MODE_INTERSECT, 13'd4, 13'd2);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd10, 8'd0);
    wait_all_results();
    load_settings(mcb_pkg::MODE_INVERT, 13'd4, 13'd2);
    send_pixel(8'd0, 8'd77);
    send_pixel(8'd1, 8'd0);
    wait_all_results();
    load_settings(MODE_SPARE_5, 13'd4, 13'd2);
    send_pixel(8'd0, 8'd0);
    wait_all_results();
    load_settings(MODE_SPARE_6, 13'd4, 13'd2);
    send_pixel(8'd18, 8'd0);
    wait_all_results();
    load_settings(MODE_SPARE_7, 13'd4, 13'd2);
    send_pixel(8'd255, 8'd3);
    wait_all_results();
  endtask

  // zero and oversized dimensions, and shrinking a frame midway
  task automatic test_dimension_edges;
    load_settings(mcb_pkg::MODE_INVERT, DIM_ZERO, DIM_ZERO);
    send_pixel(8'd0, 8'd5);
    send_pixel(8'd3, 8'd0);
    wait_all_results();
    load_settings(mcb_pkg::MODE_REPLACE, DIM_TOP, 13'd3);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd0, 8'd90);
    send_pixel(8'd0, 8'd0);
    wait_all_results();
    load_settings(mcb_pkg::MODE_REPLACE, 13'd2, 13'd1);
    send_pixel(8'd1, 8'd50);
    wait_all_results();
    load_settings(mcb_pkg::MODE_ADD, 13'd1, DIM_TOP);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd4, 8'd0);
    wait_all_results();
    load_settings(mcb_pkg::MODE_ADD, 13'd1, 13'd2);
    send_pixel(8'd0, 8'd0);
    wait_all_results();
  endtask

  task automatic test_random_frames;
    int sent;
    int pick;
    logic [2:0] mode;
    logic [mcb_pkg::DimW-1:0] width;
    logic [mcb_pkg::DimW-1:0] height;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 11);
      mode = (pick < 10) ? 3'(pick % 5) : 3'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
      width  = pick_dim();
      height = pick_dim();
      in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 9;
      out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
      load_settings(mode, width, height);
      repeat ($urandom_range(10, 60)) begin
        send_pixel(pick_pixel(), pick_pixel());
        sent++;
        if ($urandom_range(0, 99) == 0) wait_all_results();
      end
      wait_all_results();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_combine_modes();
    test_dimension_edges();
    test_random_frames();
    wait_all_results();
    repeat (4) @(posedge clk_i);
    if (pending_beats.size() != 0) begin
      mismatch_count++;
      $display("%0d result beats never arrived", pending_beats.size());
    end
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
